>>> sv/lbcf_pkg.sv
// ----------------------------------------------------------------------------
// lbcf_pkg
// Shared types, constants and helpers for the level bar with charge fill.
// ----------------------------------------------------------------------------
`default_nettype none

package lbcf_pkg;

    // Bar geometry (LED_COUNT may be 1..32)
    localparam int LED_COUNT = 10;
    localparam int FILL_W    = $clog2(LED_COUNT + 1);
    localparam int LED_W     = 10;

    // Field widths
    localparam int PCT_W     = 7;
    localparam int ACC_W     = 10;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Percentage limits
    localparam logic [ACC_W-1:0] ACC_MAX   = ACC_W'(999);
    localparam logic [ACC_W-1:0] PCT_LIMIT = ACC_W'(100);

    // Lit LED count = p * LED_COUNT / 100, by reciprocal (exact for p <= 100)
    localparam int LIT_SHIFT = 17;
    localparam int LIT_MUL   = LED_COUNT * 1311;
    localparam int LIT_MUL_W = $clog2(LIT_MUL + 1);
    localparam int LIT_PROD_W = PCT_W + LIT_MUL_W;

    // Item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Characters
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS = CFG_IDX_W'(1);
    localparam logic [TICK_W-1:0]    STEP_TICKS_RST  = TICK_W'(1000);
    localparam logic [TICK_W-1:0]    PAUSE_TICKS_RST = TICK_W'(200);

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [LED_W-1:0] led_bar;
        logic             charging_now;
        logic [PCT_W-1:0] shown_percent;
    } result_t;

    typedef struct packed {
        logic [TICK_W-1:0] step_ticks;
        logic [TICK_W-1:0] pause_ticks;
    } cfg_t;

    // Completed line from the parser
    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] percent;
        logic             flag;
    } line_t;

    // Map the internal bar onto the fixed-width LED output
    function automatic logic [LED_W-1:0] to_led(input logic [LED_COUNT-1:0] bar);
        logic [LED_W-1:0] r;
        r = '0;
        for (int j = 0; j < LED_COUNT && j < LED_W; j++) begin
            r[j] = bar[j];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/lbcf_parser.sv
// ----------------------------------------------------------------------------
// lbcf_parser
// Line parser: builds the percentage and charging flag from serial bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module lbcf_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire lbcf_pkg::item_t item,
    output lbcf_pkg::line_t    line
);
    import lbcf_pkg::*;

    logic             line_started_reg, line_started_next;
    logic [1:0]       comma_count_reg, comma_count_next;
    logic [ACC_W-1:0] percent_acc_reg, percent_acc_next;
    logic             flag_acc_reg, flag_acc_next;

    logic [3:0]       digit;
    logic [13:0]      acc_x10;
    logic             is_digit;
    logic             is_eol;

    always_comb
    begin
        digit    = 4'(item.rx_byte - CHAR_ZERO);
        is_digit = (item.rx_byte >= CHAR_ZERO) && (item.rx_byte <= CHAR_NINE);
        is_eol   = (item.rx_byte == CHAR_LF) || (item.rx_byte == CHAR_CR);
        acc_x10  = {1'b0, percent_acc_reg, 3'b000} + {3'b000, percent_acc_reg, 1'b0}
                   + {10'd0, digit};

        line_started_next = line_started_reg;
        comma_count_next  = comma_count_reg;
        percent_acc_next  = percent_acc_reg;
        flag_acc_next     = flag_acc_reg;

        line.done    = 1'b0;
        line.flag    = flag_acc_reg;
        line.percent = (percent_acc_reg > PCT_LIMIT) ? PCT_W'(PCT_LIMIT)
                                                     : PCT_W'(percent_acc_reg);

        if (item.kind == KIND_BYTE) begin
            if (is_eol) begin
                if (line_started_reg) begin
                    line.done         = 1'b1;
                    line_started_next = 1'b0;
                    comma_count_next  = 2'd0;
                    percent_acc_next  = '0;
                    flag_acc_next     = 1'b0;
                end
            end else if (item.rx_byte == CHAR_COMMA) begin
                line_started_next = 1'b1;
                if (comma_count_reg != 2'd2) begin
                    comma_count_next = comma_count_reg + 2'd1;
                end
            end else if (is_digit) begin
                line_started_next = 1'b1;
                if (comma_count_reg == 2'd0) begin
                    percent_acc_next = (acc_x10 > 14'(ACC_MAX)) ? ACC_MAX
                                                                : ACC_W'(acc_x10);
                end else if (comma_count_reg == 2'd1 && digit != 4'd0) begin
                    flag_acc_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_started_reg <= 1'b0;
            comma_count_reg  <= 2'd0;
            percent_acc_reg  <= '0;
            flag_acc_reg     <= 1'b0;
        end else if (en) begin
            line_started_reg <= line_started_next;
            comma_count_reg  <= comma_count_next;
            percent_acc_reg  <= percent_acc_next;
            flag_acc_reg     <= flag_acc_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/lbcf_display.sv
// ----------------------------------------------------------------------------
// lbcf_display
// Bar state and charge-fill animation; produces the result of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module lbcf_display (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          kind,
    input  wire lbcf_pkg::line_t line,
    input  wire lbcf_pkg::cfg_t  cfg,
    output lbcf_pkg::result_t  result
);
    import lbcf_pkg::*;

    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_FILL  = 2'd1;
    localparam logic [1:0] PHASE_PAUSE = 2'd2;

    logic [PCT_W-1:0]     stored_percent_reg, stored_percent_next;
    logic                 charging_reg, charging_next;
    logic [1:0]           phase_reg, phase_next;
    logic [FILL_W-1:0]    fill_index_reg, fill_index_next;
    logic [TICK_W-1:0]    tick_timer_reg, tick_timer_next;
    logic                 byte_seen_reg, byte_seen_next;
    logic [LED_COUNT-1:0] bar_reg, bar_next;

    logic [PCT_W-1:0]      rs_percent;
    logic                  rs_charging;
    logic [LIT_PROD_W-1:0] lit_prod;
    logic [FILL_W-1:0]     lit;
    logic [FILL_W-1:0]     fill_inc;
    logic [TICK_W:0]       timer_inc;
    logic                  do_restart;

    always_comb
    begin
        // Restart source: new line on a byte, stored values on a tick
        rs_percent  = (kind == KIND_BYTE) ? line.percent : stored_percent_reg;
        rs_charging = (kind == KIND_BYTE) ? line.flag    : charging_reg;
        lit_prod    = LIT_PROD_W'(rs_percent) * LIT_PROD_W'(LIT_MUL);
        lit         = FILL_W'(lit_prod >> LIT_SHIFT);
        fill_inc    = fill_index_reg + FILL_W'(1);
        timer_inc   = {1'b0, tick_timer_reg} + (TICK_W+1)'(1);

        stored_percent_next = stored_percent_reg;
        charging_next       = charging_reg;
        phase_next          = phase_reg;
        fill_index_next     = fill_index_reg;
        tick_timer_next     = tick_timer_reg;
        byte_seen_next      = byte_seen_reg;
        bar_next            = bar_reg;
        do_restart          = 1'b0;

        if (kind == KIND_BYTE) begin
            if (phase_reg == PHASE_FILL) begin
                byte_seen_next = 1'b1;
            end
            if (line.done) begin
                stored_percent_next = line.percent;
                charging_next       = line.flag;
                do_restart          = (phase_reg == PHASE_IDLE);
            end
        end else begin
            case (phase_reg)
                PHASE_FILL:
                begin
                    if (timer_inc >= {1'b0, cfg.step_ticks}) begin
                        if (byte_seen_reg) begin
                            do_restart = 1'b1;
                        end else begin
                            tick_timer_next = '0;
                            fill_index_next = fill_inc;
                            if (fill_inc >= FILL_W'(LED_COUNT)) begin
                                phase_next = PHASE_PAUSE;
                            end else begin
                                for (int i = 0; i < LED_COUNT; i++) begin
                                    bar_next[i] = bar_reg[i] | (FILL_W'(i) == fill_inc);
                                end
                            end
                        end
                    end else begin
                        tick_timer_next = TICK_W'(timer_inc);
                    end
                end
                PHASE_PAUSE:
                begin
                    if (timer_inc >= {1'b0, cfg.pause_ticks}) begin
                        do_restart = 1'b1;
                    end else begin
                        tick_timer_next = TICK_W'(timer_inc);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (do_restart) begin
            tick_timer_next = '0;
            byte_seen_next  = 1'b0;
            for (int i = 0; i < LED_COUNT; i++) begin
                bar_next[i] = (FILL_W'(i) < lit) || (rs_charging && FILL_W'(i) == lit);
            end
            if (!rs_charging) begin
                phase_next = PHASE_IDLE;
            end else begin
                fill_index_next = lit;
                phase_next = (lit < FILL_W'(LED_COUNT)) ? PHASE_FILL : PHASE_PAUSE;
            end
        end

        result.led_bar       = to_led(bar_next);
        result.charging_now  = charging_next;
        result.shown_percent = stored_percent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stored_percent_reg <= '0;
            charging_reg       <= 1'b0;
            phase_reg          <= PHASE_IDLE;
            fill_index_reg     <= '0;
            tick_timer_reg     <= '0;
            byte_seen_reg      <= 1'b0;
            bar_reg            <= '0;
        end else if (en) begin
            stored_percent_reg <= stored_percent_next;
            charging_reg       <= charging_next;
            phase_reg          <= phase_next;
            fill_index_reg     <= fill_index_next;
            tick_timer_reg     <= tick_timer_next;
            byte_seen_reg      <= byte_seen_next;
            bar_reg            <= bar_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/level_bar_with_charge_fill.sv
// ----------------------------------------------------------------------------
// level_bar_with_charge_fill
// Parses "percent[,flag]" lines from serial bytes and drives a thermometer
// bar with a charge-fill animation paced by millisecond ticks.
// ----------------------------------------------------------------------------
// Each request is either a received byte or a millisecond tick, and each
// produces exactly one result showing the bar, charging flag and clamped
// percentage after that request. The block takes one request per cycle
// unless the result register is full and stalled. A request first waits
// in the input register, then the single-pass update writes the parser and
// animation state and the result register together, and the result is
// presented from the result register. Both channels hold while stalled;
// when the result register is full and stalled and the input register holds
// a request, that request stays put and stall rises on the input side.
// The configuration port is always ready; write step_ticks (index 0) and
// pause_ticks (index 1) only while no request is in flight.
`default_nettype none

module level_bar_with_charge_fill (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire lbcf_pkg::item_t              in_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output lbcf_pkg::result_t                 out_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lbcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lbcf_pkg::TICK_W-1:0]  cfg_data
);
    import lbcf_pkg::*;

    logic    item_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    cfg_t    cfg_reg;

    logic    advance;
    logic    update_en;
    line_t   line;
    result_t result;

    // Move the pending request into the result register when it is free
    // or being taken this cycle
    assign advance   = !out_valid_reg || !out_stall;
    assign update_en = item_valid_reg && advance;
    assign in_stall  = item_valid_reg && !advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Input register: load whenever the held request moves on or none is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid) begin
            item_reg <= in_data;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update_en) begin
            out_data_reg <= result;
        end
    end

    // Configuration registers; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.step_ticks  <= STEP_TICKS_RST;
            cfg_reg.pause_ticks <= PAUSE_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STEP_TICKS:  cfg_reg.step_ticks  <= cfg_data;
                CFG_PAUSE_TICKS: cfg_reg.pause_ticks <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    lbcf_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (update_en),
        .item  (item_reg),
        .line  (line)
    );

    lbcf_display u_display (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (update_en),
        .kind   (item_reg.kind),
        .line   (line),
        .cfg    (cfg_reg),
        .result (result)
    );

endmodule

`default_nettype wire
